>>> sv/arpr_pkg.sv
// Shared types and constants of the ARP responder with learning table.
`default_nettype none
package arpr_pkg;

	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int LEN_W   = 11;
	localparam int FIELD_W = 16;
	localparam int OP_W    = 2;
	localparam int ENTRY_W = IP_W + MAC_W;

	// item kinds
	localparam logic [OP_W-1:0] OP_ARP    = 2'd0;
	localparam logic [OP_W-1:0] OP_LEARN  = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	// result kinds
	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

	// ARP header checks
	localparam logic [LEN_W-1:0]   ARP_MIN_LEN = 11'd28;
	localparam logic [FIELD_W-1:0] HTYPE_ETH   = 16'h0001;
	localparam logic [FIELD_W-1:0] PTYPE_IPV4  = 16'h0800;
	localparam logic [FIELD_W-1:0] OPCODE_REQ  = 16'h0001;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

>>> sv/arpr_if.sv
// Request and response channel interfaces of the ARP responder.
`default_nettype none
interface arpr_req_if
	import arpr_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [LEN_W-1:0]   pkt_len;
	logic [FIELD_W-1:0] hw_type;
	logic [FIELD_W-1:0] proto_type;
	logic [FIELD_W-1:0] arp_opcode;
	logic [MAC_W-1:0]   sender_mac;
	logic [IP_W-1:0]    sender_ip;
	logic [IP_W-1:0]    target_ip;
	logic [IP_W-1:0]    host_ip;
	logic [MAC_W-1:0]   host_mac;

	modport source (
		output valid, op, pkt_len, hw_type, proto_type, arp_opcode,
		       sender_mac, sender_ip, target_ip, host_ip, host_mac,
		input  ready
	);
	modport sink (
		input  valid, op, pkt_len, hw_type, proto_type, arp_opcode,
		       sender_mac, sender_ip, target_ip, host_ip, host_mac,
		output ready
	);
endinterface

interface arpr_rsp_if
	import arpr_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic [MAC_W-1:0] dest_mac;
	logic [IP_W-1:0]  reply_target_ip;
	logic             lookup_hit;
	logic [MAC_W-1:0] lookup_mac;

	modport source (
		output valid, result_kind, dest_mac, reply_target_ip, lookup_hit, lookup_mac,
		input  ready
	);
	modport sink (
		input  valid, result_kind, dest_mac, reply_target_ip, lookup_hit, lookup_mac,
		output ready
	);
endinterface
`default_nettype wire

>>> sv/arp_responder_with_learning_table.sv
// Top level: ARP request responder with an IP to MAC learning table.
//
// Channel  | Dir | Beat
// ---------+-----+-------------------------------------------------------
// req      | in  | ARP packet fields, learn pair or lookup IP (op selects)
// rsp      | out | ARP reply target (kind 0) or lookup answer (kind 1)
// cfg_*    | in  | write-only: index 0 own_ip, index 1 own_mac
//
// One item at a time. An item passes through an accept step, a scan of at most
// fill_count entries (ending early on a hit), an update step and a load of
// the output register. The scan reads one table entry per cycle from the
// single-port table memory.
// Reset clears the configuration, the fill count and control; the table needs
// no clearing pass, since only entries below the fill count are ever read.
// The output register lets a new beat be taken while a result waits; a
// stalled rsp holds the block in its emit step until the register frees.
`default_nettype none
module arp_responder_with_learning_table
	import arpr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MAC_W-1:0]     cfg_data,
	arpr_req_if.sink                  req,
	arpr_rsp_if.source                rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);

	// configuration
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;

	// table: {ip, mac} per entry, registered synchronous read
	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] rd_entry_s1;

	state_t state_d, state_q;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [MAC_W-1:0] hit_mac_q;

	// latched item
	logic [OP_W-1:0]  op_q;
	logic [IP_W-1:0]  key_ip_q;
	logic [MAC_W-1:0] new_mac_q;

	// output register
	logic             out_vld_q;
	logic             out_kind_q;
	logic [MAC_W-1:0] out_dest_mac_q;
	logic [IP_W-1:0]  out_tgt_ip_q;
	logic             out_hit_q;
	logic [MAC_W-1:0] out_lk_mac_q;

	// control
	logic               take;
	logic               item_ok;
	logic               pkt_ok;
	logic               match;
	logic               scan_end;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic               fill_inc;
	logic               out_load;

	// ---------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_IP:  own_ip_q  <= cfg_data[IP_W-1:0];
				CFG_OWN_MAC: own_mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// intake: an ARP item must be a well-formed request for our address
	// ---------------------------------------------------------------
	assign req.ready = (state_q == ST_IDLE);
	assign take      = req.valid && req.ready;

	assign pkt_ok = (req.pkt_len >= ARP_MIN_LEN) && (req.hw_type == HTYPE_ETH) &&
	                (req.proto_type == PTYPE_IPV4) && (req.arp_opcode == OPCODE_REQ) &&
	                (req.target_ip == own_ip_q);

	always_comb begin
		unique case (req.op)
			OP_ARP:    item_ok = pkt_ok;
			OP_LEARN:  item_ok = 1'b1;
			OP_LOOKUP: item_ok = 1'b1;
			default:   item_ok = 1'b0;   // unused op: ignored
		endcase
	end

	// ---------------------------------------------------------------
	// scan: read entry scan_q, compare it the next cycle
	// ---------------------------------------------------------------
	assign match = (state_q == ST_SCAN) && cmp_vld_s1 &&
	               (rd_entry_s1[ENTRY_W-1:MAC_W] == key_ip_q);
	// miss is known once the read stream has drained past fill_q
	assign scan_end = match || (!cmp_vld_s1 && (scan_q >= fill_q));

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && item_ok)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = (op_q == OP_LEARN) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// state outputs: memory port and output register load
	// ---------------------------------------------------------------
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = scan_q[IDX_W-1:0];
		mem_we   = 1'b0;
		mem_wa   = hit_idx_q;
		fill_inc = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_SCAN: begin
				rd_en = (scan_q < fill_q) && !match;
			end
			ST_FINISH: begin
				// learning for accepted requests and learn items
				if (op_q != OP_LOOKUP) begin
					if (hit_q) begin
						mem_we = 1'b1;
						mem_wa = hit_idx_q;
					end else if (fill_q < ENTRIES_C) begin
						mem_we   = 1'b1;
						mem_wa   = fill_q[IDX_W-1:0];
						fill_inc = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				out_load = !out_vld_q || rsp.ready;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// table memory
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= {key_ip_q, new_mac_q};
		if (rd_en)
			rd_entry_s1 <= mem[rd_addr];
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				scan_q     <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				cmp_vld_s1 <= rd_en;
				if (rd_en)
					scan_q <= scan_q + 1'b1;
				if (match)
					hit_q <= 1'b1;
			end
			if (fill_inc)
				fill_q <= fill_q + 1'b1;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (take) begin
			op_q      <= req.op;
			key_ip_q  <= (req.op == OP_ARP) ? req.sender_ip : req.host_ip;
			new_mac_q <= (req.op == OP_ARP) ? req.sender_mac : req.host_mac;
		end
		if (rd_en)
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
		if (match) begin
			hit_idx_q <= cmp_idx_s1;
			hit_mac_q <= rd_entry_s1[MAC_W-1:0];
		end
		if (out_load) begin
			if (op_q == OP_LOOKUP) begin
				out_kind_q     <= KIND_LOOKUP;
				out_dest_mac_q <= '0;
				out_tgt_ip_q   <= '0;
				out_hit_q      <= hit_q;
				out_lk_mac_q   <= hit_q ? hit_mac_q : '0;
			end else begin
				out_kind_q     <= KIND_REPLY;
				out_dest_mac_q <= new_mac_q;
				out_tgt_ip_q   <= key_ip_q;
				out_hit_q      <= 1'b0;
				out_lk_mac_q   <= '0;
			end
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.result_kind     = out_kind_q;
	assign rsp.dest_mac        = out_dest_mac_q;
	assign rsp.reply_target_ip = out_tgt_ip_q;
	assign rsp.lookup_hit      = out_hit_q;
	assign rsp.lookup_mac      = out_lk_mac_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ENTRIES_C)
		else $error("fill count beyond table size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count moved by other than one");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.result_kind == KIND_LOOKUP) && !rsp.lookup_hit)
		|-> (rsp.lookup_mac == '0))
		else $error("lookup miss carries a MAC");

	a_scan_hit_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !fill_inc) |-> hit_q)
		else $error("table update without a matching entry");

endmodule
`default_nettype wire

>>> dv/tb_arp_responder_with_learning_table.sv
`timescale 1ns / 100ps
// Self-checking testbench of the ARP responder: directed corner cases, then random traffic.
module tb_arp_responder_with_learning_table
	import arpr_pkg::*;
;

	localparam int TABLE_ENTRIES    = 16;
	localparam int RANDOM_PER_PHASE = 100;
	// learn items give no beat on rsp, so a settle waits out a full scan of the table
	localparam int QUIET_CYCLES     = 40;
	// cycles with no beat on either channel before the run is declared hung
	localparam int HANG_LIMIT       = 5000;

	// codes the package leaves unnamed: the spare op, the spare register slots, IPv6, ARP reply
	localparam logic [OP_W-1:0]      OP_SPARE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;
	localparam logic [FIELD_W-1:0]   PTYPE_IPV6   = 16'h86DD;
	localparam logic [FIELD_W-1:0]   OPCODE_REPLY = 16'h0002;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [LEN_W-1:0]   pkt_len;
		logic [FIELD_W-1:0] hw_type;
		logic [FIELD_W-1:0] proto_type;
		logic [FIELD_W-1:0] arp_opcode;
		logic [MAC_W-1:0]   sender_mac;
		logic [IP_W-1:0]    sender_ip;
		logic [IP_W-1:0]    target_ip;
		logic [IP_W-1:0]    host_ip;
		logic [MAC_W-1:0]   host_mac;
	} arp_item_t;

	typedef struct packed {
		logic             kind;
		logic [MAC_W-1:0] dest_mac;
		logic [IP_W-1:0]  target_ip;
		logic             hit;
		logic [MAC_W-1:0] mac;
	} answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MAC_W-1:0]     cfg_data;

	arpr_req_if req_ch();
	arpr_rsp_if rsp_ch();

	arp_responder_with_learning_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the block: registers, table and fill level.
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;
	logic [IP_W-1:0]  shadow_ip  [TABLE_ENTRIES];
	logic [MAC_W-1:0] shadow_mac [TABLE_ENTRIES];
	int               shadow_fill;

	answer_t pending_answers[$];
	int      mismatches;
	int      idle_pct;
	int      stall_pct;
	int      hang_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- shadow model

	function automatic int shadow_find(input logic [IP_W-1:0] ip);
		for (int i = 0; i < shadow_fill; i++) begin
			if (shadow_ip[i] == ip)
				return i;
		end
		return -1;
	endfunction

	// update on a match, append while there is room, else drop silently
	function automatic void shadow_learn(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
		int k;
		k = shadow_find(ip);
		if (k >= 0) begin
			shadow_mac[k] = mac;
		end else if (shadow_fill < TABLE_ENTRIES) begin
			shadow_ip[shadow_fill]  = ip;
			shadow_mac[shadow_fill] = mac;
			shadow_fill++;
		end
	endfunction

	// Applies one accepted beat to the shadow state; returns 1 when a rsp beat is due.
	function automatic bit derive_answer(input arp_item_t it, output answer_t ans);
		int k;
		ans = '0;
		case (it.op)
			OP_ARP: begin
				// only a well-formed Ethernet/IPv4 request aimed at us is answered
				if (it.pkt_len < ARP_MIN_LEN || it.hw_type != HTYPE_ETH ||
				    it.proto_type != PTYPE_IPV4 || it.arp_opcode != OPCODE_REQ ||
				    it.target_ip != own_ip_q)
					return 1'b0;
				shadow_learn(it.sender_ip, it.sender_mac);
				ans.kind      = KIND_REPLY;
				ans.dest_mac  = it.sender_mac;
				ans.target_ip = it.sender_ip;
				return 1'b1;
			end
			OP_LEARN: begin
				shadow_learn(it.host_ip, it.host_mac);
				return 1'b0;
			end
			OP_LOOKUP: begin
				k = shadow_find(it.host_ip);
				ans.kind = KIND_LOOKUP;
				if (k >= 0) begin
					ans.hit = 1'b1;
					ans.mac = shadow_mac[k];
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------- item builders

	function automatic logic [MAC_W-1:0] rand_mac();
		return {16'($urandom()), $urandom()};
	endfunction

	// mostly addresses already in the table or our own, so hits and updates are common
	function automatic logic [IP_W-1:0] pick_ip();
		int r;
		r = $urandom_range(99);
		if (shadow_fill != 0 && r < 55)
			return shadow_ip[$urandom_range(shadow_fill - 1)];
		if (r < 65)
			return own_ip_q;
		return $urandom();
	endfunction

	function automatic arp_item_t noise_item();
		arp_item_t it;
		it.op         = OP_W'($urandom_range(2));
		it.pkt_len    = LEN_W'($urandom_range(1500));
		it.hw_type    = FIELD_W'($urandom());
		it.proto_type = FIELD_W'($urandom());
		it.arp_opcode = FIELD_W'($urandom());
		it.sender_mac = rand_mac();
		it.sender_ip  = $urandom();
		it.target_ip  = $urandom();
		it.host_ip    = $urandom();
		it.host_mac   = rand_mac();
		return it;
	endfunction

	function automatic arp_item_t arp_request(input logic [MAC_W-1:0] mac,
	                                          input logic [IP_W-1:0] ip,
	                                          input logic [IP_W-1:0] tgt);
		arp_item_t it;
		it            = noise_item();
		it.op         = OP_ARP;
		it.pkt_len    = LEN_W'($urandom_range(1500, 28));
		it.hw_type    = HTYPE_ETH;
		it.proto_type = PTYPE_IPV4;
		it.arp_opcode = OPCODE_REQ;
		it.sender_mac = mac;
		it.sender_ip  = ip;
		it.target_ip  = tgt;
		return it;
	endfunction

	function automatic arp_item_t host_item(input logic [OP_W-1:0] op,
	                                        input logic [IP_W-1:0] ip,
	                                        input logic [MAC_W-1:0] mac);
		arp_item_t it;
		it          = noise_item();
		it.op       = op;
		it.host_ip  = ip;
		it.host_mac = mac;
		return it;
	endfunction

	// Random traffic: mostly well-formed requests and table work, some broken packets and noise.
	function automatic arp_item_t random_item();
		arp_item_t it;
		int        r;
		it = noise_item();
		r  = $urandom_range(99);
		if (r < 45) begin
			it.op = OP_ARP;
			if ($urandom_range(99) < 75) begin
				it = arp_request(rand_mac(), pick_ip(), own_ip_q);
				// spoil exactly one header check now and then
				if ($urandom_range(99) < 25) begin
					case ($urandom_range(4))
						0: it.pkt_len = LEN_W'($urandom_range(27));
						1: it.hw_type = it.hw_type ^ FIELD_W'($urandom_range(65535, 1));
						2: it.proto_type = it.proto_type ^ FIELD_W'($urandom_range(65535, 1));
						3: it.arp_opcode = it.arp_opcode ^ FIELD_W'($urandom_range(65535, 1));
						default: it.target_ip = it.target_ip ^ $urandom_range(32'hFFFF_FFFF, 1);
					endcase
				end
			end
		end else if (r < 70) begin
			it.op      = OP_LEARN;
			it.host_ip = pick_ip();
		end else if (r < 97) begin
			it.op      = OP_LOOKUP;
			it.host_ip = pick_ip();
		end else begin
			it.op = OP_SPARE;
		end
		return it;
	endfunction

	// ---------------------------------------------------------------- drivers

	// One req beat: optional idle gap, then hold valid until the block takes it.
	task automatic push_beat(input arp_item_t it);
		answer_t ans;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.op         <= it.op;
		req_ch.pkt_len    <= it.pkt_len;
		req_ch.hw_type    <= it.hw_type;
		req_ch.proto_type <= it.proto_type;
		req_ch.arp_opcode <= it.arp_opcode;
		req_ch.sender_mac <= it.sender_mac;
		req_ch.sender_ip  <= it.sender_ip;
		req_ch.target_ip  <= it.target_ip;
		req_ch.host_ip    <= it.host_ip;
		req_ch.host_mac   <= it.host_mac;
		req_ch.valid      <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (derive_answer(it, ans))
			pending_answers.push_back(ans);
	endtask

	// Drop valid, wait for every answer, then let a trailing learn finish its scan.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_OWN_IP)
			own_ip_q = data[IP_W-1:0];
		else if (idx == CFG_OWN_MAC)
			own_mac_q = data;
	endtask

	// Receiver: ready drops at random per cycle according to the current phase.
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// Each rsp beat is matched against the oldest pending answer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: rsp beat with nothing pending: expected none, actual kind %0d",
				         $time, rsp_ch.result_kind);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				check_field("result_kind", 64'(want.kind), 64'(rsp_ch.result_kind));
				check_field("dest_mac", 64'(want.dest_mac), 64'(rsp_ch.dest_mac));
				check_field("reply_target_ip", 64'(want.target_ip), 64'(rsp_ch.reply_target_ip));
				check_field("lookup_hit", 64'(want.hit), 64'(rsp_ch.lookup_hit));
				check_field("lookup_mac", 64'(want.mac), 64'(rsp_ch.lookup_mac));
			end
		end
	end

	// Hang detector: any beat on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			hang_count = 0;
		else
			hang_count++;
		if (hang_count >= HANG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d answers pending",
			         $time, HANG_LIMIT, pending_answers.size());
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Empty table right after reset: a lookup must miss.
	task automatic test_empty_table();
		push_beat(host_item(OP_LOOKUP, 32'h0000_0000, rand_mac()));
	endtask

	// With own_ip still at its reset value of zero, a minimum-length request for 0.0.0.0
	// is answered and its all-ones sender gets learned.
	task automatic test_reply_after_reset();
		arp_item_t it;
		it = arp_request({MAC_W{1'b1}}, 32'hFFFF_FFFF, 32'h0000_0000);
		it.pkt_len = ARP_MIN_LEN;
		push_beat(it);
	endtask

	// Both registers to all ones; the spare slots must change nothing.
	task automatic test_register_writes();
		settle();
		write_reg(CFG_OWN_IP, {MAC_W{1'b1}});
		write_reg(CFG_OWN_MAC, {MAC_W{1'b1}});
		write_reg(CFG_SPARE_2, rand_mac());
		write_reg(CFG_SPARE_3, rand_mac());
	endtask

	// Header checks: one accepted request at full length, then each drop reason on its own.
	// The dropped senders share one address, and a lookup proves none of them was learned.
	task automatic test_arp_checks();
		arp_item_t it;
		it = arp_request('0, 32'h0000_0000, own_ip_q);
		it.pkt_len = LEN_W'(1500);
		push_beat(it);
		for (int c = 0; c < 5; c++) begin
			it = arp_request(rand_mac(), 32'h0A0A_0A0A, own_ip_q);
			case (c)
				0: it.pkt_len    = ARP_MIN_LEN - 1'b1;
				1: it.hw_type    = 16'hFFFF;
				2: it.proto_type = PTYPE_IPV6;
				3: it.arp_opcode = OPCODE_REPLY;
				default: it.target_ip = own_ip_q ^ 32'h0000_0001;
			endcase
			push_beat(it);
		end
		push_beat(host_item(OP_LOOKUP, 32'h0A0A_0A0A, rand_mac()));
	endtask

	// Op 3 must be swallowed without a beat or a table change.
	task automatic test_unknown_op();
		arp_item_t it;
		it = noise_item();
		it.op = OP_SPARE;
		push_beat(it);
	endtask

	// Fill the table, then: a new pair is dropped, a request from a new host is still
	// answered but not learned, and an existing entry still takes an update.
	task automatic test_table_full();
		int room;
		room = TABLE_ENTRIES - shadow_fill;
		for (int i = 0; i < room; i++)
			push_beat(host_item(OP_LEARN, 32'h0A00_0100 + i, rand_mac()));
		push_beat(host_item(OP_LEARN, 32'hC0A8_0001, rand_mac()));
		push_beat(arp_request(rand_mac(), 32'hC0A8_0002, own_ip_q));
		push_beat(host_item(OP_LOOKUP, 32'hC0A8_0002, rand_mac()));
		push_beat(host_item(OP_LEARN, 32'h0A00_0100, rand_mac()));
		push_beat(host_item(OP_LOOKUP, 32'h0A00_0100, rand_mac()));
	endtask

	// One phase of random traffic under a given register setting and idle profile.
	// Now and then the sender holds off until every answer is back.
	task automatic test_random_traffic(input int idle, input int stall,
	                                   input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
		settle();
		write_reg(CFG_OWN_IP, {16'($urandom()), ip});
		write_reg(CFG_OWN_MAC, mac);
		idle_pct  = idle;
		stall_pct = stall;
		for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
			if ($urandom_range(49) == 0)
				settle();
			push_beat(random_item());
		end
	endtask

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_OWN_IP;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.op        = OP_ARP;
		req_ch.pkt_len   = '0;
		req_ch.hw_type   = '0;
		req_ch.proto_type = '0;
		req_ch.arp_opcode = '0;
		req_ch.sender_mac = '0;
		req_ch.sender_ip = '0;
		req_ch.target_ip = '0;
		req_ch.host_ip   = '0;
		req_ch.host_mac  = '0;
		rsp_ch.ready     = 1'b0;
		own_ip_q         = '0;
		own_mac_q        = '0;
		shadow_fill      = 0;
		mismatches       = 0;
		idle_pct         = 0;
		stall_pct        = 0;
		hang_count       = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_reply_after_reset();
		test_register_writes();
		test_arp_checks();
		test_unknown_op();
		test_table_full();

		// idle profiles: none, sender gaps, receiver stalls, both; registers swept incl. zero
		test_random_traffic(0, 0, $urandom(), rand_mac());
		test_random_traffic(55, 0, '0, '0);
		test_random_traffic(0, 55, $urandom(), rand_mac());
		test_random_traffic(30, 30, {IP_W{1'b1}}, {MAC_W{1'b1}});

		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> arp_responder_with_learning_table.f
sv/arpr_pkg.sv
sv/arpr_if.sv
sv/arp_responder_with_learning_table.sv
dv/tb_arp_responder_with_learning_table.sv
